FILE: rtl/cnv_pkg.sv
// Shared constants, types and codes for the RGBA 11x11 convolution block.
// No dependencies; every file but cnv_ram imports this package.
package cnv_pkg;

   // filter and image geometry
   localparam int TAPS       = 11;
   localparam int LINES      = TAPS - 1;
   localparam int NTAP       = TAPS * TAPS;
   localparam int MAX_LINE   = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int CHANNELS   = 4;
   localparam int PIXEL_BITS = 8;
   localparam int COEF_BITS  = 16;
   localparam int FRAC_BITS  = COEF_BITS - 1;

   // field widths of the channels
   localparam int TAP_W     = 4;
   localparam int CH_W      = 2;
   localparam int WREG_W    = 11;
   localparam int HREG_W    = 13;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 13;

   // internal widths
   localparam int COL_W       = $clog2(MAX_LINE);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int LINE_W      = CHANNELS * PIXEL_BITS;
   localparam int TREE_LEVELS = $clog2(NTAP);
   localparam int NLEAF       = 1 << TREE_LEVELS;
   localparam int PROD_W      = COEF_BITS + PIXEL_BITS + 1;
   localparam int ACC_W       = PROD_W + TREE_LEVELS;
   localparam int LANE_LAT    = TREE_LEVELS + 2;

   // result queue
   localparam int FIFO_DEPTH = 32;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_PIXEL = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_PADDED_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_PADDED_HEIGHT = CSR_IDX_W'(1);

   typedef logic [PIXEL_BITS-1:0] pix_type;

   // coefficient write toward one lane
   typedef struct packed {
      logic                        en;
      logic [TAP_W-1:0]            row;
      logic [TAP_W-1:0]            col;
      logic signed [COEF_BITS-1:0] value;
   } coef_wr_type;

   // one result pixel
   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
      pix_type alpha;
      logic    end_of_row;
      logic    end_of_frame;
   } rsp_data_type;

   // per-stage tracking of an item behind the lanes
   typedef struct packed {
      logic valid;
      logic emit;
      logic eor;
      logic eof;
   } trk_type;

endpackage

FILE: rtl/cnv_if.sv
// Channel interfaces: pixel/coefficient request, result and register write.
// Depends on cnv_pkg.
interface cnv_req_if import cnv_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic                        op;
   logic [TAP_W-1:0]            tap_row;
   logic [TAP_W-1:0]            tap_col;
   logic [CH_W-1:0]             channel;
   logic signed [COEF_BITS-1:0] coef_value;
   pix_type                     red_in;
   pix_type                     green_in;
   pix_type                     blue_in;
   pix_type                     alpha_in;

   modport source (output valid, op, tap_row, tap_col, channel, coef_value,
                   red_in, green_in, blue_in, alpha_in, input ready);
   modport sink   (input valid, op, tap_row, tap_col, channel, coef_value,
                   red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface cnv_rsp_if import cnv_pkg::*; ();
   logic    valid;
   logic    ready;
   pix_type red_out;
   pix_type green_out;
   pix_type blue_out;
   pix_type alpha_out;
   logic    end_of_row;
   logic    end_of_frame;

   modport source (output valid, red_out, green_out, blue_out, alpha_out,
                   end_of_row, end_of_frame, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, alpha_out,
                   end_of_row, end_of_frame, output ready);
endinterface

interface cnv_csr_if import cnv_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [CSR_DAT_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rgba_2d_convolution_11x11.sv
// RGBA 11x11 convolution top level: counters, line buffer RAM, four channel
// lanes and the merging stage. Depends on cnv_pkg, the interfaces, cnv_ram,
// cnv_lane and cnv_fifo.
//
// Usage: req_chan carries one transaction per item. op load writes one
// Q1.15 coefficient (tap_row, tap_col, channel); op pixel delivers one RGBA
// pixel of a halo-padded frame in raster order. rsp_chan gives one filtered
// pixel per full 11x11 window, with end_of_row and end_of_frame marks.
// csr_chan writes padded_width (index 0) or padded_height (index 1); either
// write restarts the frame. Write registers only while the block is idle.
// Throughput: one item per clock while req_chan.ready is high. A result
// passes through the line buffer read, window shift, one product stage, a
// seven-level registered adder tree, rounding and the result queue. A
// 32-entry result queue with credit counting keeps req_chan.ready high
// while results wait; past the reset sweep it drops only once 32 items are
// in flight or queued. Reset clears counters, window and queue, then sweeps
// each line buffer RAM entry to zero, during which req_chan.ready is low
// (csr writes are still taken). Coefficients are undefined until loaded.
module rgba_2d_convolution_11x11 import cnv_pkg::*; (
   input logic     clock,
   input logic     reset,
   cnv_req_if.sink   req_chan,
   cnv_rsp_if.source rsp_chan,
   cnv_csr_if.sink   csr_chan
);

   logic [WREG_W-1:0] width_ff;
   logic [HREG_W-1:0] height_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ROW_W-1:0]  row_ff;
   logic              clear_ff;
   logic [COL_W-1:0]  clear_cnt_ff;
   logic [FIFO_AW:0]  occ_ff;
   logic [FIFO_AW:0]  occ_in;

   logic              req_fire;
   logic              rsp_fire;
   logic [WREG_W-1:0] w_eff;
   logic [HREG_W-1:0] h_eff;
   logic [COL_W-1:0]  c_cur;
   logic              eor;
   logic              eof;
   logic              emit;

   // stage 1: item beside the RAM read data
   logic                        s1_valid_ff;
   logic                        s1_pixel_ff;
   logic [COL_W-1:0]            s1_col_ff;
   logic [LINE_W-1:0]           s1_pix_ff;
   logic [TAP_W-1:0]            s1_row_tap_ff;
   logic [TAP_W-1:0]            s1_col_tap_ff;
   logic [CH_W-1:0]             s1_ch_ff;
   logic signed [COEF_BITS-1:0] s1_coef_ff;
   trk_type                     s1_trk_ff;

   // stage 2: item at the product stage
   logic                        s2_load_ff;
   logic [TAP_W-1:0]            s2_row_tap_ff;
   logic [TAP_W-1:0]            s2_col_tap_ff;
   logic [CH_W-1:0]             s2_ch_ff;
   logic signed [COEF_BITS-1:0] s2_coef_ff;
   trk_type                     s2_trk_ff;
   trk_type                     trk_ff [LANE_LAT];

   logic [LINES*LINE_W-1:0] ram_rd;
   logic [LINES*LINE_W-1:0] ram_wr_data;
   logic                    ram_wr_en;
   logic [COL_W-1:0]        ram_wr_addr;

   pix_type      lane_col [CHANNELS][TAPS];
   pix_type      lane_out [CHANNELS];
   coef_wr_type  lane_wr  [CHANNELS];
   rsp_data_type push_data;
   rsp_data_type head;
   logic         push;
   logic         drop;
   logic         not_empty;

   assign req_chan.ready = !clear_ff && (occ_ff < (FIFO_AW+1)'(FIFO_DEPTH));
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign rsp_fire       = rsp_chan.valid && rsp_chan.ready;

   // effective frame size and position of the incoming pixel
   always_comb begin
      w_eff = width_ff;
      if (width_ff < WREG_W'(TAPS))     w_eff = WREG_W'(TAPS);
      if (width_ff > WREG_W'(MAX_LINE)) w_eff = WREG_W'(MAX_LINE);
      h_eff = height_ff;
      if (height_ff < HREG_W'(TAPS))       h_eff = HREG_W'(TAPS);
      if (height_ff > HREG_W'(MAX_HEIGHT)) h_eff = HREG_W'(MAX_HEIGHT);
      c_cur = ({1'b0, col_ff} >= w_eff) ? '0 : col_ff;
      eor   = ({1'b0, c_cur} == w_eff - 1'b1);
      eof   = eor && ({1'b0, row_ff} == h_eff - 1'b1);
      emit  = (row_ff >= ROW_W'(TAPS - 1)) && (c_cur >= COL_W'(TAPS - 1));
   end

   // registers and frame counters
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WREG_W'(MAX_LINE);
         height_ff <= HREG_W'(MAX_HEIGHT);
         col_ff    <= '0;
         row_ff    <= '0;
      end else if (csr_chan.valid) begin
         if (csr_chan.index == REG_PADDED_WIDTH) begin
            width_ff <= csr_chan.data[WREG_W-1:0];
            col_ff   <= '0;
            row_ff   <= '0;
         end else if (csr_chan.index == REG_PADDED_HEIGHT) begin
            height_ff <= csr_chan.data[HREG_W-1:0];
            col_ff    <= '0;
            row_ff    <= '0;
         end
      end else if (req_fire && req_chan.op == OP_PIXEL) begin
         if (eor) begin
            col_ff <= '0;
            row_ff <= eof ? '0 : row_ff + 1'b1;
         end else begin
            col_ff <= c_cur + 1'b1;
         end
      end
   end

   // clearing sweep of the line buffer after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff     <= 1'b1;
         clear_cnt_ff <= '0;
      end else if (clear_ff) begin
         clear_cnt_ff <= clear_cnt_ff + 1'b1;
         if (clear_cnt_ff == COL_W'(MAX_LINE - 1)) clear_ff <= 1'b0;
      end
   end

   // stage 1 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_trk_ff   <= '0;
      end else begin
         s1_valid_ff     <= req_fire;
         s1_trk_ff.valid <= req_fire;
         s1_trk_ff.emit  <= req_fire && req_chan.op == OP_PIXEL && emit;
         s1_trk_ff.eor   <= eor;
         s1_trk_ff.eof   <= eof;
      end
   end

   always_ff @(posedge clock) begin
      s1_pixel_ff   <= req_chan.op == OP_PIXEL;
      s1_col_ff     <= c_cur;
      s1_pix_ff     <= {req_chan.alpha_in, req_chan.blue_in,
                        req_chan.green_in, req_chan.red_in};
      s1_row_tap_ff <= req_chan.tap_row;
      s1_col_tap_ff <= req_chan.tap_col;
      s1_ch_ff      <= req_chan.channel;
      s1_coef_ff    <= req_chan.coef_value;
   end

   // line buffer: read at the incoming column, write the shifted lines back
   always_comb begin
      for (int i = 0; i < LINES - 1; i++) begin
         ram_wr_data[i*LINE_W +: LINE_W] = ram_rd[(i+1)*LINE_W +: LINE_W];
      end
      ram_wr_data[(LINES-1)*LINE_W +: LINE_W] = s1_pix_ff;
      if (clear_ff) ram_wr_data = '0;
      ram_wr_en   = clear_ff || (s1_valid_ff && s1_pixel_ff);
      ram_wr_addr = clear_ff ? clear_cnt_ff : s1_col_ff;
   end

   cnv_ram #(
      .WIDTH (LINES * LINE_W),
      .DEPTH (MAX_LINE)
   ) u_line_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_addr    (c_cur),
      .rd_data_ff (ram_rd)
   );

   // stage 2 capture
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_load_ff <= 1'b0;
         s2_trk_ff  <= '0;
      end else begin
         s2_load_ff <= s1_valid_ff && !s1_pixel_ff;
         s2_trk_ff  <= s1_trk_ff;
      end
   end

   always_ff @(posedge clock) begin
      s2_row_tap_ff <= s1_row_tap_ff;
      s2_col_tap_ff <= s1_col_tap_ff;
      s2_ch_ff      <= s1_ch_ff;
      s2_coef_ff    <= s1_coef_ff;
   end

   // lanes, one per color channel
   for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
      always_comb begin
         for (int i = 0; i < LINES; i++) begin
            lane_col[k][i] = ram_rd[i*LINE_W + k*PIXEL_BITS +: PIXEL_BITS];
         end
         lane_col[k][TAPS-1] = s1_pix_ff[k*PIXEL_BITS +: PIXEL_BITS];
         lane_wr[k].en    = s2_load_ff && (s2_ch_ff == CH_W'(k));
         lane_wr[k].row   = s2_row_tap_ff;
         lane_wr[k].col   = s2_col_tap_ff;
         lane_wr[k].value = s2_coef_ff;
      end

      cnv_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .win_shift  (s1_valid_ff && s1_pixel_ff),
         .win_col    (lane_col[k]),
         .coef_wr    (lane_wr[k]),
         .pix_out_ff (lane_out[k])
      );
   end

   // track items alongside the lane pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LANE_LAT; i++) trk_ff[i] <= '0;
      end else begin
         trk_ff[0] <= s2_trk_ff;
         for (int i = 1; i < LANE_LAT; i++) trk_ff[i] <= trk_ff[i-1];
      end
   end

   // merge the lane results into one transaction
   always_comb begin
      push                   = trk_ff[LANE_LAT-1].valid && trk_ff[LANE_LAT-1].emit;
      drop                   = trk_ff[LANE_LAT-1].valid && !trk_ff[LANE_LAT-1].emit;
      push_data.red          = lane_out[0];
      push_data.green        = lane_out[1];
      push_data.blue         = lane_out[2];
      push_data.alpha        = lane_out[3];
      push_data.end_of_row   = trk_ff[LANE_LAT-1].eor;
      push_data.end_of_frame = trk_ff[LANE_LAT-1].eof;
   end

   cnv_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_fire),
      .not_empty (not_empty),
      .head      (head)
   );

   assign rsp_chan.valid        = not_empty;
   assign rsp_chan.red_out      = head.red;
   assign rsp_chan.green_out    = head.green;
   assign rsp_chan.blue_out     = head.blue;
   assign rsp_chan.alpha_out    = head.alpha;
   assign rsp_chan.end_of_row   = head.end_of_row;
   assign rsp_chan.end_of_frame = head.end_of_frame;

   // credits: items in flight plus queued results
   always_comb begin
      occ_in = occ_ff + (FIFO_AW+1)'(req_fire)
               - (FIFO_AW+1)'(rsp_fire) - (FIFO_AW+1)'(drop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

`ifndef SYNTH
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("credit count above queue depth");
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> !req_chan.ready)
      else $error("transaction accepted during line buffer clear");
   a_rsp_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> occ_ff != '0)
      else $error("result pending without credit");
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      push && push_data.end_of_frame |-> push_data.end_of_row)
      else $error("frame end without row end");
`endif

endmodule

FILE: rtl/cnv_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module cnv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data_ff
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

endmodule

FILE: rtl/cnv_fifo.sv
// Result queue between the lane pipeline and the result channel.
// Depends on cnv_pkg.
module cnv_fifo import cnv_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_data_type push_data,
   input  logic         pop,
   output logic         not_empty,
   output rsp_data_type head
);

   rsp_data_type       mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff;
   logic [FIFO_AW-1:0] rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;
   logic [FIFO_AW:0]   count_in;

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // store a pushed transaction
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (!push && pop) count_in = count_ff - 1'b1;
   end

   // advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != (FIFO_AW+1)'(FIFO_DEPTH))
      else $error("result queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("result queue underflow");
`endif

endmodule

FILE: rtl/cnv_lane.sv
// One color-channel lane: window, coefficients, multipliers, adder tree,
// rounding and saturation. Depends on cnv_pkg.
module cnv_lane import cnv_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        win_shift,
   input  pix_type     win_col [TAPS],
   input  coef_wr_type coef_wr,
   output pix_type     pix_out_ff
);

   localparam logic [ACC_W:0] HALF   = (ACC_W+1)'(1) << (FRAC_BITS - 1);
   localparam logic [ACC_W:0] PIXMAX = (ACC_W+1)'((1 << PIXEL_BITS) - 1);

   pix_type                     win_ff  [TAPS][TAPS];
   logic signed [COEF_BITS-1:0] coef_ff [NTAP];
   logic signed [ACC_W-1:0]     tree_ff [TREE_LEVELS+1][NLEAF];
   logic signed [ACC_W:0]       rnd;
   logic signed [ACC_W:0]       shifted;

   // shift the window left and insert the new column
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (win_shift) begin
         for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS - 1; j++) begin
               win_ff[i][j] <= win_ff[i][j+1];
            end
            win_ff[i][TAPS-1] <= win_col[i];
         end
      end
   end

   // coefficient registers, one per tap
   always_ff @(posedge clock) begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            if (coef_wr.en && coef_wr.row == TAP_W'(i) && coef_wr.col == TAP_W'(j)) begin
               coef_ff[i*TAPS+j] <= coef_wr.value;
            end
         end
      end
   end

   // products and registered adder tree
   for (genvar l = 0; l <= TREE_LEVELS; l++) begin : g_lvl
      for (genvar n = 0; n < NLEAF; n++) begin : g_node
         if (l == 0 && n < NTAP) begin : g_prod
            always_ff @(posedge clock) begin
               tree_ff[l][n] <= ACC_W'(coef_ff[n] *
                  $signed({1'b0, win_ff[n/TAPS][n%TAPS]}));
            end
         end else if (l > 0 && n < (NLEAF >> l)) begin : g_add
            always_ff @(posedge clock) begin
               tree_ff[l][n] <= tree_ff[l-1][2*n] + tree_ff[l-1][2*n+1];
            end
         end else begin : g_zero
            always_ff @(posedge clock) begin
               tree_ff[l][n] <= '0;
            end
         end
      end
   end

   // round, drop the fraction and saturate to the pixel range
   always_comb begin
      rnd     = $signed({tree_ff[TREE_LEVELS][0][ACC_W-1], tree_ff[TREE_LEVELS][0]})
                + $signed(HALF);
      shifted = rnd >>> FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (rnd < 0) begin
         pix_out_ff <= '0;
      end else if (shifted > $signed(PIXMAX)) begin
         pix_out_ff <= PIXMAX[PIXEL_BITS-1:0];
      end else begin
         pix_out_ff <= shifted[PIXEL_BITS-1:0];
      end
   end

endmodule

FILE: sim/tb_rgba_2d_convolution_11x11.sv
// Self-checking testbench for the RGBA 11x11 convolution block.
// Depends on cnv_pkg, the channel interfaces and rgba_2d_convolution_11x11.
module tb_rgba_2d_convolution_11x11;
   import cnv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 24;
   localparam int RANDOM_ITEMS   = 100;
   localparam int LONG_HOLD      = 400;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = CSR_IDX_W'(2);

   typedef struct packed {
      logic                        op;
      logic [TAP_W-1:0]            tap_row;
      logic [TAP_W-1:0]            tap_col;
      logic [CH_W-1:0]             channel;
      logic signed [COEF_BITS-1:0] coef;
      pix_type                     red;
      pix_type                     green;
      pix_type                     blue;
      pix_type                     alpha;
   } conv_item_type;

   typedef struct packed {
      conv_item_type item;
      logic          no_rsp;
   } dir_row_type;

   // extremes of every field; all rows run under the reset geometry, so none emits
   localparam dir_row_type DIRECTED[14] = '{
      '{'{OP_LOAD,  4'd5,  4'd5,  2'd0, 16'sh7fff, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_LOAD,  4'd0,  4'd0,  2'd1, 16'sh8000, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1},
      '{'{OP_LOAD,  4'd10, 4'd10, 2'd2, 16'sh0001, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_LOAD,  4'd10, 4'd0,  2'd3, 16'shffff, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_LOAD,  4'd0,  4'd10, 2'd3, 16'sh4000, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_LOAD,  4'd11, 4'd3,  2'd0, 16'sh1234, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_LOAD,  4'd15, 4'd15, 2'd1, 16'sh7fff, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_LOAD,  4'd2,  4'd12, 2'd2, 16'sh8000, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_PIXEL, 4'd0,  4'd0,  2'd0, 16'sh0000, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1},
      '{'{OP_PIXEL, 4'd0,  4'd0,  2'd0, 16'sh0000, 8'hff, 8'hff, 8'hff, 8'hff}, 1'b1},
      '{'{OP_PIXEL, 4'd0,  4'd0,  2'd0, 16'sh0000, 8'hff, 8'h00, 8'hff, 8'h00}, 1'b1},
      '{'{OP_PIXEL, 4'd0,  4'd0,  2'd0, 16'sh0000, 8'h00, 8'hff, 8'h00, 8'hff}, 1'b1},
      '{'{OP_PIXEL, 4'd15, 4'd15, 2'd3, 16'sh8000, 8'h80, 8'h7f, 8'h01, 8'hfe}, 1'b1},
      '{'{OP_LOAD,  4'd5,  4'd5,  2'd1, 16'sh0000, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   cnv_req_if req_bus ();
   cnv_rsp_if rsp_bus ();
   cnv_csr_if csr_bus ();

   rgba_2d_convolution_11x11 i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's state
   logic signed [COEF_BITS-1:0] coef_mem [TAPS][TAPS][CHANNELS];
   pix_type                     line_mem [LINES][MAX_LINE][CHANNELS];
   pix_type                     win_mem  [TAPS][TAPS][CHANNELS];
   int                          col_cnt;
   int                          row_cnt;
   logic [WREG_W-1:0]           width_reg;
   logic [HREG_W-1:0]           height_reg;

   rsp_data_type pending_pixels [$];
   int           mismatch_count = 0;
   bit           quiet_mode = 1'b0;
   bit           hold_request = 1'b0;

   // advance the shadow by one accepted pixel; return 1 with the filtered pixel
   function automatic bit convolve_pixel(input conv_item_type it, output rsp_data_type px);
      pix_type pin [CHANNELS];
      pix_type colv [TAPS][CHANNELS];
      int      w, h, c, r;
      bit      emit, eor, eof;
      longint  acc, t;
      pix_type sat [CHANNELS];
      w = width_reg;
      h = height_reg;
      if (w < TAPS) w = TAPS;
      if (w > MAX_LINE) w = MAX_LINE;
      if (h < TAPS) h = TAPS;
      if (h > MAX_HEIGHT) h = MAX_HEIGHT;
      c = (col_cnt >= w) ? 0 : col_cnt;
      r = (row_cnt >= h) ? 0 : row_cnt;
      pin[0] = it.red;
      pin[1] = it.green;
      pin[2] = it.blue;
      pin[3] = it.alpha;
      for (int k = 0; k < CHANNELS; k++) begin
         for (int i = 0; i < LINES; i++) colv[i][k] = line_mem[i][c][k];
         colv[TAPS-1][k] = pin[k];
         for (int i = 0; i < LINES - 1; i++) line_mem[i][c][k] = line_mem[i+1][c][k];
         line_mem[LINES-1][c][k] = pin[k];
         for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS - 1; j++) win_mem[i][j][k] = win_mem[i][j+1][k];
            win_mem[i][TAPS-1][k] = colv[i][k];
         end
      end
      emit = (r >= TAPS - 1) && (c >= TAPS - 1);
      eor  = (c == w - 1);
      eof  = eor && (r == h - 1);
      if (eor) begin
         col_cnt = 0;
         row_cnt = eof ? 0 : r + 1;
      end else begin
         col_cnt = c + 1;
         row_cnt = r;
      end
      for (int k = 0; k < CHANNELS; k++) begin
         acc = 0;
         for (int i = 0; i < TAPS; i++)
            for (int j = 0; j < TAPS; j++)
               acc += longint'(coef_mem[i][j][k]) * longint'({1'b0, win_mem[i][j][k]});
         t = acc + (longint'(1) << (FRAC_BITS - 1));
         if (t < 0) sat[k] = '0;
         else if ((t >>> FRAC_BITS) > 255) sat[k] = '1;
         else sat[k] = pix_type'(t >>> FRAC_BITS);
      end
      px.red          = sat[0];
      px.green        = sat[1];
      px.blue         = sat[2];
      px.alpha        = sat[3];
      px.end_of_row   = eor;
      px.end_of_frame = eof;
      return emit;
   endfunction

   function automatic logic signed [COEF_BITS-1:0] rand_coef();
      if ($urandom_range(0, 3) != 0) return COEF_BITS'($signed($urandom_range(0, 1000)) - 300);
      return COEF_BITS'($urandom);
   endfunction

   function automatic pix_type rand_pix();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return pix_type'($urandom);
      endcase
   endfunction

   function automatic conv_item_type rand_item(input logic op);
      conv_item_type it;
      it.op      = op;
      it.tap_row = (op == OP_LOAD) ? TAP_W'($urandom_range(0, TAPS - 1)) : TAP_W'($urandom);
      it.tap_col = (op == OP_LOAD) ? TAP_W'($urandom_range(0, TAPS - 1)) : TAP_W'($urandom);
      it.channel = CH_W'($urandom);
      it.coef    = rand_coef();
      it.red     = rand_pix();
      it.green   = rand_pix();
      it.blue    = rand_pix();
      it.alpha   = rand_pix();
      return it;
   endfunction

   // offer one transaction, wait for acceptance, then update the shadow
   task automatic send_item(input conv_item_type it, output bit emitted);
      int           gap;
      rsp_data_type px;
      if (!quiet_mode && $urandom_range(0, 11) == 0) begin
         gap = $urandom_range(1, 18);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.op         <= it.op;
      req_bus.tap_row    <= it.tap_row;
      req_bus.tap_col    <= it.tap_col;
      req_bus.channel    <= it.channel;
      req_bus.coef_value <= it.coef;
      req_bus.red_in     <= it.red;
      req_bus.green_in   <= it.green;
      req_bus.blue_in    <= it.blue;
      req_bus.alpha_in   <= it.alpha;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      emitted = 1'b0;
      if (it.op == OP_LOAD) begin
         if (it.tap_row < TAPS && it.tap_col < TAPS)
            coef_mem[it.tap_row][it.tap_col][it.channel] = it.coef;
      end else if (convolve_pixel(it, px)) begin
         pending_pixels.push_back(px);
         emitted = 1'b1;
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= CSR_DAT_W'(value);
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
      if (idx == REG_PADDED_WIDTH) width_reg = WREG_W'(value);
      else if (idx == REG_PADDED_HEIGHT) height_reg = HREG_W'(value);
      if (idx == REG_PADDED_WIDTH || idx == REG_PADDED_HEIGHT) begin
         col_cnt = 0;
         row_cnt = 0;
      end
   endtask

   // drain every expected pixel, then let trailing items leave the pipeline
   task automatic wait_idle();
      req_bus.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // one geometry setting and a stream of pixels with loads mixed in at load_pct percent
   task automatic run_frames(input int w, input int h, input int npix, input int load_pct,
                             inout int items);
      bit dummy;
      wait_idle();
      write_reg(REG_PADDED_WIDTH, w);
      write_reg(REG_PADDED_HEIGHT, h);
      for (int n = 0; n < npix; n++) begin
         if ($urandom_range(0, 99) < load_pct) begin
            send_item(rand_item(OP_LOAD), dummy);
            items++;
         end
         send_item(rand_item(OP_PIXEL), dummy);
         items++;
      end
   endtask

   // result side: check, then pick the next ready level
   initial begin : rsp_side
      int           gap;
      int           hold_cnt;
      rsp_data_type want;
      gap = 0;
      hold_cnt = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_pixels.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected result transaction at %0t", $realtime);
            end else begin
               want = pending_pixels.pop_front();
               if (rsp_bus.red_out !== want.red || rsp_bus.green_out !== want.green ||
                   rsp_bus.blue_out !== want.blue || rsp_bus.alpha_out !== want.alpha ||
                   rsp_bus.end_of_row !== want.end_of_row ||
                   rsp_bus.end_of_frame !== want.end_of_frame) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch at %0t: exp %h %h %h %h %b %b got %h %h %h %h %b %b",
                              $realtime, want.red, want.green, want.blue, want.alpha,
                              want.end_of_row, want.end_of_frame, rsp_bus.red_out,
                              rsp_bus.green_out, rsp_bus.blue_out, rsp_bus.alpha_out,
                              rsp_bus.end_of_row, rsp_bus.end_of_frame);
               end
            end
         end
         // start the long hold once results begin to come out
         if (hold_request && rsp_bus.valid) begin
            hold_request = 1'b0;
            hold_cnt = LONG_HOLD;
         end
         if (hold_cnt == 0 && gap == 0 && !quiet_mode && $urandom_range(0, 15) == 0)
            gap = $urandom_range(1, 18);
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_bus.ready <= 1'b0;
         end else if (gap > 0) begin
            gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // end the run when nothing moves for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int items;
      bit emitted;
      req_bus.valid      <= 1'b0;
      req_bus.op         <= OP_LOAD;
      req_bus.tap_row    <= '0;
      req_bus.tap_col    <= '0;
      req_bus.channel    <= '0;
      req_bus.coef_value <= '0;
      req_bus.red_in     <= '0;
      req_bus.green_in   <= '0;
      req_bus.blue_in    <= '0;
      req_bus.alpha_in   <= '0;
      csr_bus.valid      <= 1'b0;
      csr_bus.index      <= '0;
      csr_bus.data       <= '0;
      for (int i = 0; i < TAPS; i++)
         for (int j = 0; j < TAPS; j++)
            for (int k = 0; k < CHANNELS; k++) begin
               win_mem[i][j][k] = '0;
               coef_mem[i][j][k] = '0;
               if (i < LINES)
                  for (int x = 0; x < MAX_LINE; x++) line_mem[i][x][k] = '0;
            end
      col_cnt = 0;
      row_cnt = 0;
      width_reg = WREG_W'(MAX_LINE);
      height_reg = HREG_W'(MAX_HEIGHT);
      items = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // give every tap of every channel a value before any window is read
      for (int i = 0; i < TAPS; i++)
         for (int j = 0; j < TAPS; j++)
            for (int k = 0; k < CHANNELS; k++)
               send_item('{OP_LOAD, TAP_W'(i), TAP_W'(j), CH_W'(k), rand_coef(),
                           rand_pix(), rand_pix(), rand_pix(), rand_pix()}, emitted);

      // directed rows under the reset geometry
      foreach (DIRECTED[n]) begin
         send_item(DIRECTED[n].item, emitted);
         if (DIRECTED[n].no_rsp && emitted) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("directed row %0d produced a result", n);
         end
      end

      // smallest frame, then clamped register values and an ignored index
      run_frames(TAPS, TAPS, TAPS * TAPS, 0, items);
      wait_idle();
      write_reg(REG_UNUSED, 8191);
      run_frames(5, 0, TAPS * TAPS, 3, items);

      // random small frames, some cut short by the next register write
      items = 0;
      while (items < RANDOM_ITEMS) begin
         int w, h, npix;
         w = $urandom_range(TAPS, 16);
         h = $urandom_range(TAPS, 13);
         npix = w * h * $urandom_range(1, 2);
         if ($urandom_range(0, 3) == 0) npix = npix - $urandom_range(1, w * 3);
         run_frames(w, h, npix, 5, items);
      end

      // the receiver stalls long enough to back up the input
      wait_idle();
      hold_request = 1'b1;
      run_frames(24, TAPS + 2, 24 * (TAPS + 2), 0, items);

      // one full frame, no idling on either side
      wait_idle();
      quiet_mode = 1'b1;
      run_frames(TAPS + 1, TAPS + 1, (TAPS + 1) * (TAPS + 1), 0, items);

      wait_idle();
      if (pending_pixels.size() == 0 && mismatch_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
rtl/cnv_pkg.sv
rtl/cnv_if.sv
rtl/cnv_ram.sv
rtl/cnv_fifo.sv
rtl/cnv_lane.sv
rtl/rgba_2d_convolution_11x11.sv
sim/tb_rgba_2d_convolution_11x11.sv
